// File: hdl/ckbt_pkg.sv
// ----------------------------------------------------------------------------
// ckbt_pkg
// Shared types, widths and codes of the color key blob tracker.
// ----------------------------------------------------------------------------
package ckbt_pkg;

    // Field widths
    localparam int COLOR_W     = 8;
    localparam int COORD_W     = 10;
    localparam int SECONDS_W   = 32;
    localparam int PERCENT_W   = 9;
    localparam int SUM_W       = 29;
    localparam int COUNT_W     = 20;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;

    // Window arithmetic runs two bits above the coordinate width
    localparam int SPAN_W    = 12;
    // Ratio test: 100 * green against percent * color
    localparam int PRODUCT_W = 17;

    // Restoring divider: one quotient bit per step
    localparam int DIV_STEPS = SUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Parameter defaults
    localparam int FRAME_WIDTH_DEF  = 640;
    localparam int FRAME_HEIGHT_DEF = 480;
    localparam int SEARCH_RANGE_DEF = 1000;

    // Constants
    localparam logic [PRODUCT_W-1:0] GREEN_SCALE = PRODUCT_W'(100);
    localparam logic [COUNT_W-1:0]   COUNT_MAX   = '1;
    localparam logic [COLOR_W-1:0]   COLOR_OFF   = 8'h00;
    localparam logic [COLOR_W-1:0]   COLOR_FULL  = 8'hFF;

    // Register reset values
    localparam logic [COLOR_W-1:0]   GREEN_THRESHOLD_RST = 8'd100;
    localparam logic [PERCENT_W-1:0] GREEN_RED_RST       = 9'd200;
    localparam logic [PERCENT_W-1:0] GREEN_BLUE_RST      = 9'd200;
    localparam logic [COLOR_W-1:0]   HOLD_OFF_RST        = 8'd2;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_GREEN_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GREEN_RED       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GREEN_BLUE      = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_OFF        = 2'd3;

    // Result kinds
    localparam logic KIND_PIXEL   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [COLOR_W-1:0]   red;
        logic [COLOR_W-1:0]   green;
        logic [COLOR_W-1:0]   blue;
        logic [COORD_W-1:0]   column;
        logic [COORD_W-1:0]   row;
        logic                 frame_end;
        logic [SECONDS_W-1:0] now_seconds;
    } pixel_t;

    typedef struct packed {
        logic                 kind;
        logic [COLOR_W-1:0]   out_red;
        logic [COLOR_W-1:0]   out_green;
        logic [COLOR_W-1:0]   out_blue;
        logic                 found;
        logic [COORD_W-1:0]   centroid_x;
        logic [COORD_W-1:0]   centroid_y;
        logic [COORD_W-1:0]   box_left;
        logic [COORD_W-1:0]   box_top;
        logic [COORD_W-1:0]   box_right;
        logic [COORD_W-1:0]   box_bottom;
        logic                 advance;
    } result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;        // pixel transfer: test, accumulate, load pixel result
        logic div_load;      // load divider operands from the accumulators
        logic div_step;      // one restoring division step
        logic load_summary;  // load summary, update tracking state, clear frame
    } ckbt_cmd_t;

endpackage

// File: hdl/ckbt_pixel_if.sv
// ----------------------------------------------------------------------------
// ckbt_pixel_if
// Pixel stream channel: valid/ready handshake with pixel payload.
// ----------------------------------------------------------------------------
interface ckbt_pixel_if;
    import ckbt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [COLOR_W-1:0]   red;
    logic [COLOR_W-1:0]   green;
    logic [COLOR_W-1:0]   blue;
    logic [COORD_W-1:0]   column;
    logic [COORD_W-1:0]   row;
    logic                 frame_end;
    logic [SECONDS_W-1:0] now_seconds;

    modport source (
        output valid, red, green, blue, column, row, frame_end, now_seconds,
        input  ready
    );

    modport sink (
        input  valid, red, green, blue, column, row, frame_end, now_seconds,
        output ready
    );
endinterface

// File: hdl/ckbt_result_if.sv
// ----------------------------------------------------------------------------
// ckbt_result_if
// Result stream channel: valid/ready handshake with pixel or summary payload.
// ----------------------------------------------------------------------------
interface ckbt_result_if;
    import ckbt_pkg::*;

    logic               valid;
    logic               ready;
    logic               kind;
    logic [COLOR_W-1:0] out_red;
    logic [COLOR_W-1:0] out_green;
    logic [COLOR_W-1:0] out_blue;
    logic               found;
    logic [COORD_W-1:0] centroid_x;
    logic [COORD_W-1:0] centroid_y;
    logic [COORD_W-1:0] box_left;
    logic [COORD_W-1:0] box_top;
    logic [COORD_W-1:0] box_right;
    logic [COORD_W-1:0] box_bottom;
    logic               advance;

    modport source (
        output valid, kind, out_red, out_green, out_blue, found, centroid_x,
               centroid_y, box_left, box_top, box_right, box_bottom, advance,
        input  ready
    );

    modport sink (
        input  valid, kind, out_red, out_green, out_blue, found, centroid_x,
               centroid_y, box_left, box_top, box_right, box_bottom, advance,
        output ready
    );
endinterface

// File: hdl/ckbt_ctrl.sv
// ----------------------------------------------------------------------------
// ckbt_ctrl
// Controller: pixel handshake, divider sequencing and output register valid.
// ----------------------------------------------------------------------------
module ckbt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pixel_valid,
    input  logic                 pixel_frame_end,
    output logic                 pixel_ready,
    input  logic                 result_ready,
    output logic                 result_valid,
    output ckbt_pkg::ckbt_cmd_t  cmd
);
    import ckbt_pkg::*;

    typedef enum logic [1:0] {
        ST_PIXEL,
        ST_LOAD,
        ST_DIVIDE,
        ST_SUMMARY
    } state_t;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_free;
    logic                accept;

    // Output register can take a new result this cycle
    assign out_free    = !out_valid_reg || result_ready;
    assign pixel_ready = (state_reg == ST_PIXEL) && out_free;
    assign accept      = pixel_valid && pixel_ready;

    // Decode commands
    always_comb
    begin
        cmd.accept       = accept;
        cmd.div_load     = (state_reg == ST_LOAD);
        cmd.div_step     = (state_reg == ST_DIVIDE);
        cmd.load_summary = (state_reg == ST_SUMMARY) && out_free;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_PIXEL:
            begin
                if (accept && pixel_frame_end)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                step_next  = '0;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_SUMMARY;
                end
            end
            ST_SUMMARY:
            begin
                if (out_free)
                begin
                    state_next = ST_PIXEL;
                end
            end
            default:
            begin
                state_next = ST_PIXEL;
            end
        endcase
    end

    // Hold output valid until the transfer
    always_comb
    begin
        priority if (accept || cmd.load_summary)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_PIXEL;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

endmodule

// File: hdl/ckbt_datapath.sv
// ----------------------------------------------------------------------------
// ckbt_datapath
// Datapath: color key test, frame accumulators, centroid divider,
// tracking state and the output payload register.
// ----------------------------------------------------------------------------
module ckbt_datapath #(
    parameter int FRAME_WIDTH  = ckbt_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = ckbt_pkg::FRAME_HEIGHT_DEF,
    parameter int SEARCH_RANGE = ckbt_pkg::SEARCH_RANGE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ckbt_pkg::ckbt_cmd_t               cmd,
    input  ckbt_pkg::pixel_t                  pixel,
    input  logic                              cfg_we,
    input  logic [ckbt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ckbt_pkg::CFG_DATA_W-1:0]   cfg_data,
    output ckbt_pkg::result_t                 result
);
    import ckbt_pkg::*;

    localparam logic [SPAN_W-1:0] SPAN_WIDTH  = SPAN_W'(FRAME_WIDTH);
    localparam logic [SPAN_W-1:0] SPAN_HEIGHT = SPAN_W'(FRAME_HEIGHT);
    localparam logic [SPAN_W-1:0] SPAN_RANGE  = SPAN_W'(SEARCH_RANGE);

    // Window membership on one axis
    function automatic logic in_span(
        input logic [COORD_W-1:0] pos,
        input logic               centred,
        input logic [COORD_W-1:0] centre,
        input logic [SPAN_W-1:0]  size
    );
        logic [SPAN_W-1:0] lo;
        logic [SPAN_W-1:0] hi;
        logic [SPAN_W-1:0] c;
        logic [SPAN_W-1:0] s;
        logic [SPAN_W-1:0] p;
        c  = SPAN_W'(centre);
        p  = SPAN_W'(pos);
        s  = c + SPAN_RANGE;
        lo = '0;
        hi = size;
        if (centred)
        begin
            lo = (c > SPAN_RANGE) ? (c - SPAN_RANGE) : '0;
            hi = (s < size) ? s : size;
        end
        return (p >= lo) && (p < hi);
    endfunction

    // One restoring division step: {remainder, quotient bit}
    function automatic logic [COUNT_W:0] div_bit(
        input logic [COUNT_W-1:0] rem,
        input logic               next_bit,
        input logic [COUNT_W-1:0] divisor
    );
        logic [COUNT_W:0] shifted;
        logic [COUNT_W:0] diff;
        shifted = {rem, next_bit};
        diff    = shifted - {1'b0, divisor};
        if (shifted >= {1'b0, divisor})
        begin
            return {diff[COUNT_W-1:0], 1'b1};
        end
        return {shifted[COUNT_W-1:0], 1'b0};
    endfunction

    // Configuration registers
    logic [COLOR_W-1:0]   thr_reg;
    logic [PERCENT_W-1:0] red_pct_reg;
    logic [PERCENT_W-1:0] blue_pct_reg;
    logic [COLOR_W-1:0]   hold_reg;

    // Tracking state
    logic                 win_valid_reg;
    logic [COORD_W-1:0]   win_x_reg;
    logic [COORD_W-1:0]   win_y_reg;
    logic                 prev_valid_reg;
    logic [COORD_W-1:0]   prev_left_reg;
    logic [COORD_W-1:0]   prev_top_reg;
    logic                 idle_reg;
    logic [SECONDS_W-1:0] last_adv_reg;

    // Frame accumulators
    logic [SUM_W-1:0]     col_sum_reg;
    logic [SUM_W-1:0]     row_sum_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic                 box_any_reg;
    logic [COORD_W-1:0]   box_l_reg;
    logic [COORD_W-1:0]   box_t_reg;
    logic [COORD_W-1:0]   box_r_reg;
    logic [COORD_W-1:0]   box_b_reg;

    // Divider and frame-end time
    logic [SUM_W-1:0]     quo_x_reg;
    logic [SUM_W-1:0]     quo_y_reg;
    logic [COUNT_W-1:0]   rem_x_reg;
    logic [COUNT_W-1:0]   rem_y_reg;
    logic [SECONDS_W-1:0] now_reg;

    result_t              result_reg;
    result_t              result_next;

    logic                 in_window;
    logic [PRODUCT_W-1:0] green_scaled;
    logic [PRODUCT_W-1:0] red_scaled;
    logic [PRODUCT_W-1:0] blue_scaled;
    logic                 match;
    logic [SUM_W:0]       col_sum_add;
    logic [SUM_W:0]       row_sum_add;
    logic                 fits;
    logic [COUNT_W:0]     step_x;
    logic [COUNT_W:0]     step_y;
    logic                 found;
    logic [SECONDS_W-1:0] elapsed;
    logic                 advance;
    logic [COORD_W-1:0]   cent_x;
    logic [COORD_W-1:0]   cent_y;

    // Color key test
    always_comb
    begin
        in_window = in_span(pixel.column, win_valid_reg, win_x_reg, SPAN_WIDTH) &&
                    in_span(pixel.row, win_valid_reg, win_y_reg, SPAN_HEIGHT);
        green_scaled = PRODUCT_W'(pixel.green) * GREEN_SCALE;
        red_scaled   = PRODUCT_W'(red_pct_reg) * PRODUCT_W'(pixel.red);
        blue_scaled  = PRODUCT_W'(blue_pct_reg) * PRODUCT_W'(pixel.blue);
        match = in_window && (pixel.green > thr_reg) &&
                (green_scaled > red_scaled) && (green_scaled > blue_scaled);
    end

    // Accumulate only while sums and count stay in range
    assign col_sum_add = {1'b0, col_sum_reg} + (SUM_W + 1)'(pixel.column);
    assign row_sum_add = {1'b0, row_sum_reg} + (SUM_W + 1)'(pixel.row);
    assign fits = (count_reg != COUNT_MAX) && !col_sum_add[SUM_W] && !row_sum_add[SUM_W];

    assign step_x = div_bit(rem_x_reg, quo_x_reg[SUM_W-1], count_reg);
    assign step_y = div_bit(rem_y_reg, quo_y_reg[SUM_W-1], count_reg);

    // Frame summary decision
    always_comb
    begin
        found   = (count_reg != '0);
        cent_x  = quo_x_reg[COORD_W-1:0];
        cent_y  = quo_y_reg[COORD_W-1:0];
        elapsed = now_reg - last_adv_reg;
        advance = found && prev_valid_reg && (prev_left_reg != box_l_reg) &&
                  (prev_top_reg != box_t_reg) && !idle_reg &&
                  (elapsed > SECONDS_W'(hold_reg));
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= GREEN_THRESHOLD_RST;
            red_pct_reg  <= GREEN_RED_RST;
            blue_pct_reg <= GREEN_BLUE_RST;
            hold_reg     <= HOLD_OFF_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GREEN_THRESHOLD: thr_reg      <= cfg_data[COLOR_W-1:0];
                REG_GREEN_RED:       red_pct_reg  <= cfg_data[PERCENT_W-1:0];
                REG_GREEN_BLUE:      blue_pct_reg <= cfg_data[PERCENT_W-1:0];
                REG_HOLD_OFF:        hold_reg     <= cfg_data[COLOR_W-1:0];
                default:             thr_reg      <= thr_reg;
            endcase
        end
    end

    // Accumulators, box and tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_valid_reg  <= 1'b0;
            win_x_reg      <= '0;
            win_y_reg      <= '0;
            prev_valid_reg <= 1'b0;
            prev_left_reg  <= '0;
            prev_top_reg   <= '0;
            idle_reg       <= 1'b0;
            last_adv_reg   <= '0;
            col_sum_reg    <= '0;
            row_sum_reg    <= '0;
            count_reg      <= '0;
            box_any_reg    <= 1'b0;
            box_l_reg      <= '0;
            box_t_reg      <= '0;
            box_r_reg      <= '0;
            box_b_reg      <= '0;
        end
        else if (cmd.accept && match)
        begin
            if (fits)
            begin
                col_sum_reg <= col_sum_add[SUM_W-1:0];
                row_sum_reg <= row_sum_add[SUM_W-1:0];
                count_reg   <= count_reg + COUNT_W'(1);
            end
            box_any_reg <= 1'b1;
            if (!box_any_reg || (pixel.column < box_l_reg))
            begin
                box_l_reg <= pixel.column;
            end
            if (!box_any_reg || (pixel.column > box_r_reg))
            begin
                box_r_reg <= pixel.column;
            end
            if (!box_any_reg || (pixel.row < box_t_reg))
            begin
                box_t_reg <= pixel.row;
            end
            if (!box_any_reg || (pixel.row > box_b_reg))
            begin
                box_b_reg <= pixel.row;
            end
        end
        else if (cmd.load_summary)
        begin
            if (found)
            begin
                win_valid_reg  <= 1'b1;
                win_x_reg      <= cent_x;
                win_y_reg      <= cent_y;
                prev_valid_reg <= 1'b1;
                prev_left_reg  <= box_l_reg;
                prev_top_reg   <= box_t_reg;
                if (advance)
                begin
                    idle_reg     <= 1'b1;
                    last_adv_reg <= now_reg;
                end
            end
            else
            begin
                win_valid_reg <= 1'b0;
                win_x_reg     <= '0;
                win_y_reg     <= '0;
                idle_reg      <= 1'b0;
            end
            // drop the finished frame
            col_sum_reg <= '0;
            row_sum_reg <= '0;
            count_reg   <= '0;
            box_any_reg <= 1'b0;
            box_l_reg   <= '0;
            box_t_reg   <= '0;
            box_r_reg   <= '0;
            box_b_reg   <= '0;
        end
    end

    // Centroid divider: quotient shifts in while the dividend shifts out
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            now_reg <= pixel.now_seconds;
        end
        if (cmd.div_load)
        begin
            quo_x_reg <= col_sum_reg;
            quo_y_reg <= row_sum_reg;
            rem_x_reg <= '0;
            rem_y_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_x_reg <= step_x[COUNT_W:1];
            rem_y_reg <= step_y[COUNT_W:1];
            quo_x_reg <= {quo_x_reg[SUM_W-2:0], step_x[0]};
            quo_y_reg <= {quo_y_reg[SUM_W-2:0], step_y[0]};
        end
    end

    // Build the next output payload
    always_comb
    begin
        result_next = result_reg;
        if (cmd.accept)
        begin
            result_next           = '0;
            result_next.kind      = KIND_PIXEL;
            result_next.out_red   = match ? COLOR_OFF  : pixel.red;
            result_next.out_green = match ? COLOR_FULL : pixel.green;
            result_next.out_blue  = match ? COLOR_OFF  : pixel.blue;
        end
        else if (cmd.load_summary)
        begin
            result_next         = '0;
            result_next.kind    = KIND_SUMMARY;
            result_next.found   = found;
            result_next.advance = advance;
            if (found)
            begin
                result_next.centroid_x = cent_x;
                result_next.centroid_y = cent_y;
                result_next.box_left   = box_l_reg;
                result_next.box_top    = box_t_reg;
                result_next.box_right  = box_r_reg;
                result_next.box_bottom = box_b_reg;
            end
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

// File: hdl/color_key_blob_tracker.sv
// ----------------------------------------------------------------------------
// color_key_blob_tracker
// Green color key with blob centroid, bounding box and advance pulse.
//
//   channel   direction   handshake      payload
//   pixel     in          valid/ready    red green blue column row frame_end
//                                        now_seconds
//   result    out         valid/ready    kind out_red/green/blue found
//                                        centroid_x/y box_* advance
//   cfg       in          cfg_we         cfg_index cfg_data
//
// A new pixel is taken whenever the controller is in its pixel state and the
// output register is free; the pixel result sits in a single output register.
// A frame-end pixel holds off the next pixel through the load state, 29 steps
// of the two restoring dividers (one quotient bit per step for each centroid
// axis), then the summary state. A stalled result stalls the pixel input; reset
// clears all tracking state and loads the register defaults.
// ----------------------------------------------------------------------------
module color_key_blob_tracker #(
    parameter int FRAME_WIDTH  = ckbt_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = ckbt_pkg::FRAME_HEIGHT_DEF,
    parameter int SEARCH_RANGE = ckbt_pkg::SEARCH_RANGE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    ckbt_pixel_if.sink                        pixel,
    ckbt_result_if.source                     result,
    input  logic                              cfg_we,
    input  logic [ckbt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ckbt_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ckbt_pkg::*;

    ckbt_cmd_t cmd;
    pixel_t    pixel_data;
    result_t   result_data;

    // Pack the pixel payload
    assign pixel_data.red         = pixel.red;
    assign pixel_data.green       = pixel.green;
    assign pixel_data.blue        = pixel.blue;
    assign pixel_data.column      = pixel.column;
    assign pixel_data.row         = pixel.row;
    assign pixel_data.frame_end   = pixel.frame_end;
    assign pixel_data.now_seconds = pixel.now_seconds;

    ckbt_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .pixel_valid     (pixel.valid),
        .pixel_frame_end (pixel.frame_end),
        .pixel_ready     (pixel.ready),
        .result_ready    (result.ready),
        .result_valid    (result.valid),
        .cmd             (cmd)
    );

    ckbt_datapath #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .SEARCH_RANGE (SEARCH_RANGE)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .pixel     (pixel_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result_data)
    );

    // Unpack the result payload
    assign result.kind       = result_data.kind;
    assign result.out_red    = result_data.out_red;
    assign result.out_green  = result_data.out_green;
    assign result.out_blue   = result_data.out_blue;
    assign result.found      = result_data.found;
    assign result.centroid_x = result_data.centroid_x;
    assign result.centroid_y = result_data.centroid_y;
    assign result.box_left   = result_data.box_left;
    assign result.box_top    = result_data.box_top;
    assign result.box_right  = result_data.box_right;
    assign result.box_bottom = result_data.box_bottom;
    assign result.advance    = result_data.advance;

    // A frame-end transfer blocks the next pixel while the summary is built
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel.valid && pixel.ready && pixel.frame_end |=> !pixel.ready)
        else $error("pixel accepted during frame summary");

    // Pixel result and summary never load together
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.accept && cmd.load_summary))
        else $error("pixel and summary loaded in one cycle");

    // An advance needs a blob
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.kind == KIND_SUMMARY) && !result.found |-> !result.advance)
        else $error("advance without a blob");

    // Divider only runs while no pixel is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_load || cmd.div_step) |-> !pixel.ready)
        else $error("pixel ready during centroid division");

endmodule
